/* src/spvg_pkg.sv */
package spvg_pkg;

    localparam int MAX_POINTS_DEF   = 200;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int INV_GAIN         = 39797;
    localparam int CW               = 40;

    localparam logic [2:0] REG_CENTER_X   = 3'd0;
    localparam logic [2:0] REG_CENTER_Y   = 3'd1;
    localparam logic [2:0] REG_OUTER_X    = 3'd2;
    localparam logic [2:0] REG_OUTER_Y    = 3'd3;
    localparam logic [2:0] REG_INNER_X    = 3'd4;
    localparam logic [2:0] REG_INNER_Y    = 3'd5;
    localparam logic [2:0] REG_NUM_POINTS = 3'd6;

    function automatic logic [13:0] atan_turn(input logic [4:0] i);
        logic [13:0] r;
        case (i)
            5'd0:  r = 14'd8192;
            5'd1:  r = 14'd4836;
            5'd2:  r = 14'd2555;
            5'd3:  r = 14'd1297;
            5'd4:  r = 14'd651;
            5'd5:  r = 14'd326;
            5'd6:  r = 14'd163;
            5'd7:  r = 14'd81;
            5'd8:  r = 14'd41;
            5'd9:  r = 14'd20;
            5'd10: r = 14'd10;
            5'd11: r = 14'd5;
            5'd12: r = 14'd3;
            5'd13: r = 14'd1;
            5'd14: r = 14'd1;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic start;
        logic vec_mode;
    } cordic_ctl_t;

endpackage

/* src/spvg_cordic.sv */
module spvg_cordic
    import spvg_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cordic_ctl_t          ctl,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [17:0]   z_in,
    output logic                 done,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [17:0]   z_out
);
    localparam int SW = $clog2(CORDIC_STEPS + 1);

    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [17:0]   z_reg;
    logic [SW-1:0]        step_reg;
    logic                 busy_reg, vec_reg, done_reg;
    logic                 dir;
    logic signed [CW-1:0] xs, ys;
    logic signed [17:0]   at;

    always_comb
    begin
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        at = (step_reg < SW'(ATAN_LEN)) ? $signed({4'b0, atan_turn(5'(step_reg))}) : 18'sd0;
        dir = vec_reg ? (y_reg >= 0) : (z_reg >= 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            vec_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= !ctl.start && busy_reg && (step_reg == SW'(CORDIC_STEPS));
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                vec_reg  <= ctl.vec_mode;
                x_reg    <= x_in;
                y_reg    <= y_in;
                z_reg    <= z_in;
            end
            else if (busy_reg)
            begin
                if (step_reg == SW'(CORDIC_STEPS))
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    // vectoring: dir=1 clockwise; rotation: dir=1 ccw
                    if (dir)
                    begin
                        x_reg <= vec_reg ? x_reg + ys : x_reg - ys;
                        y_reg <= vec_reg ? y_reg - xs : y_reg + xs;
                    end
                    else
                    begin
                        x_reg <= vec_reg ? x_reg - ys : x_reg + ys;
                        y_reg <= vec_reg ? y_reg + xs : y_reg - xs;
                    end
                    if (vec_reg)
                        z_reg <= dir ? z_reg + at : z_reg - at;
                    else
                        z_reg <= dir ? z_reg - at : z_reg + at;
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

/* src/star_polygon_vertex_gen.sv */
// channel  | signals                                   | dir
// in       | in_valid in_ready vertex_index            | in
// out      | out_valid out_ready point_x point_y closing last | out
// cfg      | cfg_we cfg_index cfg_data                 | in
// Index 0 runs two vectorings (outer and inner radius) and one rotation;
// other indices run one rotation; a closing beat is an extra output beat.
// The offset divide by 2N (after the vectorings for index 0) runs one
// quotient bit a cycle, then the shared CORDIC unit does the rotation.
// Reset clears config, radius, angle, state and out_valid; N resets to 3.
// A held result stalls the block until taken; in_ready is low while busy.
module star_polygon_vertex_gen
    import spvg_pkg::*;
#(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [8:0]         vertex_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] point_x,
    output logic signed [15:0] point_y,
    output logic               closing,
    output logic               last,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_VO, S_VOW, S_VI, S_VIW, S_DIV, S_ROT, S_ROTW,
        S_MUL, S_OUT1, S_OUT2
    } state_t;

    state_t state_reg;
    logic signed [15:0] cx_reg, cy_reg, ox_reg, oy_reg, ix_reg, iy_reg;
    logic [7:0]  np_reg;
    logic [16:0] orad_reg, irad_reg;
    logic [15:0] base_reg;
    logic signed [15:0] lx_reg, ly_reg, fx_reg, fy_reg;
    logic        hf_reg;
    logic [8:0]  k_reg;
    logic [7:0]  n_reg;
    logic [25:0] rem_reg;
    logic [16:0] quo_reg;
    logic [4:0]  dcnt_reg;
    logic signed [15:0] px_reg, py_reg;
    logic        emit1_reg, clo2_reg;
    logic        ov_reg, oc_reg, ol_reg;
    logic signed [15:0] ox_o_reg, oy_o_reg;
    logic        neg_reg;
    logic signed [17:0] a_reg;
    logic [CW-1:0] prod_reg;

    cordic_ctl_t ctl;
    logic signed [CW-1:0] cxi, cyi, cxo, cyo;
    logic signed [17:0] czi, czo;
    logic cdone;

    spvg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .x_in(cxi), .y_in(cyi), .z_in(czi),
        .done(cdone), .x_out(cxo), .y_out(cyo), .z_out(czo)
    );

    logic [7:0] n_eff;
    logic signed [16:0] dx, dy;
    logic [CW-1:0] rmul;
    logic [16:0] rad_v;
    logic signed [CW-1:0] sx, sy, vx, vy;
    logic signed [15:0] rx, ry;
    logic [16:0] rsel;
    logic [15:0] ang;
    logic out_load;

    function automatic logic signed [15:0] sat(input logic signed [CW-1:0] v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return v[15:0];
    endfunction

    always_comb
    begin
        n_eff = (np_reg < 8'd3) ? 8'd3 :
                (32'(np_reg) > MAX_POINTS) ? 8'(MAX_POINTS) : np_reg;
        if (state_reg == S_VO)
        begin
            dx = 17'(ox_reg) - 17'(cx_reg);
            dy = 17'(oy_reg) - 17'(cy_reg);
        end
        else
        begin
            dx = 17'(ix_reg) - 17'(cx_reg);
            dy = 17'(iy_reg) - 17'(cy_reg);
        end
        rsel = k_reg[0] ? irad_reg : orad_reg;
        ang  = base_reg + quo_reg[15:0];
        ctl = '0;
        cxi = '0;
        cyi = '0;
        czi = '0;
        if (state_reg == S_VO || state_reg == S_VI)
        begin
            ctl.start = 1'b1;
            ctl.vec_mode = 1'b1;
            if (dx < 0)
            begin
                cxi = -(CW'(dx) <<< 2);
                cyi = -(CW'(dy) <<< 2);
                czi = 18'sd32768;
            end
            else
            begin
                cxi = CW'(dx) <<< 2;
                cyi = CW'(dy) <<< 2;
            end
        end
        else if (state_reg == S_ROT)
        begin
            ctl.start = 1'b1;
            cxi = neg_reg ? -$signed(prod_reg) : $signed(prod_reg);
            czi = a_reg;
        end
        rmul = (cxo < 0) ? '0 : CW'(cxo[CW-1:0]) * CW'(INV_GAIN) + (CW'(1) << 17);
        rad_v = ((rmul >> 18) > 131071) ? 17'h1ffff : 17'(rmul >> 18);
        sx = cxo + (CW'(cx_reg) <<< 2) + CW'(2);
        sy = cyo + (CW'(cy_reg) <<< 2) + CW'(2);
        vx = sx >>> 2;
        vy = sy >>> 2;
        rx = sat(vx);
        ry = sat(vy);
    end

    logic signed [17:0] a_c;
    logic neg_c;
    always_comb
    begin
        a_c = $signed({2'b0, ang});
        if (ang >= 16'd32768) a_c = a_c - 18'sd65536;
        neg_c = 1'b0;
        if (a_c > 16384 || a_c < -16384)
        begin
            a_c = (a_c > 0) ? a_c - 18'sd32768 : a_c + 18'sd32768;
            neg_c = 1'b1;
        end
    end

    assign out_load = ((state_reg == S_OUT1 && emit1_reg) || state_reg == S_OUT2)
                      && (!ov_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cx_reg <= '0; cy_reg <= '0; ox_reg <= '0; oy_reg <= '0;
            ix_reg <= '0; iy_reg <= '0; np_reg <= 8'd3;
            orad_reg <= '0; irad_reg <= '0; base_reg <= '0;
            lx_reg <= '0; ly_reg <= '0; fx_reg <= '0; fy_reg <= '0;
            hf_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CENTER_X:   cx_reg <= cfg_data;
                    REG_CENTER_Y:   cy_reg <= cfg_data;
                    REG_OUTER_X:    ox_reg <= cfg_data;
                    REG_OUTER_Y:    oy_reg <= cfg_data;
                    REG_INNER_X:    ix_reg <= cfg_data;
                    REG_INNER_Y:    iy_reg <= cfg_data;
                    REG_NUM_POINTS: np_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_load)
                ov_reg <= 1'b1;
            else if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        k_reg <= vertex_index;
                        state_reg <= S_CHK;
                    end
                S_CHK:
                begin
                    n_reg <= n_eff;
                    rem_reg <= {1'b0, k_reg, 16'd0} + 26'(n_eff);
                    quo_reg <= '0;
                    dcnt_reg <= 5'd0;
                    if (10'(k_reg) >= {1'b0, n_eff, 1'b0})
                        state_reg <= S_IDLE;
                    else if (k_reg == 9'd0)
                        state_reg <= S_VO;
                    else
                        state_reg <= S_DIV;
                end
                S_VO: state_reg <= S_VOW;
                S_VOW:
                    if (cdone)
                    begin
                        orad_reg <= rad_v;
                        base_reg <= (ox_reg == cx_reg && oy_reg == cy_reg) ? 16'd0 : czo[15:0];
                        state_reg <= S_VI;
                    end
                S_VI: state_reg <= S_VIW;
                S_VIW:
                    if (cdone)
                    begin
                        irad_reg <= rad_v;
                        hf_reg <= 1'b0;
                        state_reg <= S_DIV;
                    end
                S_DIV:
                begin
                    // restoring divide by 2N, one quotient bit per cycle
                    if (rem_reg >= ({17'd0, n_reg, 1'b0} << (16 - dcnt_reg)))
                    begin
                        rem_reg <= rem_reg - ({17'd0, n_reg, 1'b0} << (16 - dcnt_reg));
                        quo_reg <= {quo_reg[15:0], 1'b1};
                    end
                    else
                        quo_reg <= {quo_reg[15:0], 1'b0};
                    if (dcnt_reg == 5'd16)
                        state_reg <= S_MUL;
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                S_MUL:
                begin
                    prod_reg <= ((CW'(rsel) * CW'(4 * INV_GAIN)) + CW'(32768)) >> 16;
                    a_reg <= a_c;
                    neg_reg <= neg_c;
                    state_reg <= S_ROT;
                end
                S_ROT: state_reg <= S_ROTW;
                S_ROTW:
                    if (cdone)
                    begin
                        px_reg <= rx;
                        py_reg <= ry;
                        emit1_reg <= !(hf_reg && rx == lx_reg && ry == ly_reg);
                        clo2_reg <= (10'(k_reg) == {1'b0, n_reg, 1'b0} - 10'd1);
                        state_reg <= S_OUT1;
                    end
                S_OUT1:
                    if (!ov_reg || out_ready)
                    begin
                        if (emit1_reg)
                        begin
                            ox_o_reg <= px_reg; oy_o_reg <= py_reg;
                            oc_reg <= 1'b0; ol_reg <= !clo2_reg;
                            lx_reg <= px_reg; ly_reg <= py_reg;
                            if (!hf_reg)
                            begin
                                fx_reg <= px_reg; fy_reg <= py_reg; hf_reg <= 1'b1;
                            end
                        end
                        state_reg <= clo2_reg ? S_OUT2 : S_IDLE;
                    end
                S_OUT2:
                    if (!ov_reg || out_ready)
                    begin
                        ox_o_reg <= fx_reg; oy_o_reg <= fy_reg;
                        oc_reg <= 1'b1; ol_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign point_x   = ox_o_reg;
    assign point_y   = oy_o_reg;
    assign closing   = oc_reg;
    assign last      = ol_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y))
        else $error("result dropped while stalled");
    a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && closing |-> last)
        else $error("closing beat not last");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cdone |-> !in_ready)
        else $error("ready while computing");
endmodule
